[sv/mmcrc_pkg.sv]
// shared types, register codes and crc update functions for the multi-mode crc byte engine
// no dependencies
package mmcrc_pkg;

	typedef enum logic [1:0] {
		MODE_CRC16  = 2'd0,
		MODE_XMODEM = 2'd1,
		MODE_CRC8   = 2'd2,
		MODE_NONE   = 2'd3
	} crc_mode_t;

	typedef enum logic [0:0] {
		REG_MODE = 1'b0,
		REG_SEED = 1'b1
	} reg_idx_t;

	typedef struct packed {
		crc_mode_t   mode;
		logic [15:0] seed;
	} crc_cfg_t;

	localparam logic [15:0] POLY_CRC16  = 16'hA001;
	localparam logic [15:0] POLY_XMODEM = 16'h1021;
	localparam logic [15:0] POLY_CRC8   = 16'h008C;
	localparam logic [15:0] MSB_MASK    = 16'h8000;

	// reflected crc-16, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ POLY_CRC16) : (c >> 1);
		end
		return c;
	endfunction

	// msb-first ccitt, one byte
	function automatic logic [15:0] xmodem_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = ((c & MSB_MASK) != 16'h0000) ? ((c << 1) ^ POLY_XMODEM) : (c << 1);
		end
		return c;
	endfunction

	// reflected crc-8 over the full 16-bit register
	function automatic logic [15:0] crc8_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ POLY_CRC8) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[sv/mmcrc_core.sv]
// running crc register and per-byte update for the three crc modes; the unused mode passes the start value through
// depends on mmcrc_pkg
module mmcrc_core
	import mmcrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  crc_cfg_t    cfg,
	output logic [15:0] crc_next,
	output logic        msg_open
);

	logic [15:0] running_crc_q;
	logic        msg_open_q;
	logic [15:0] crc_start;

	// a new message starts from the seed
	assign crc_start = msg_open_q ? running_crc_q : cfg.seed;

	always_comb begin
		case (cfg.mode)
			MODE_CRC16:  crc_next = crc16_byte(crc_start, data_byte);
			MODE_XMODEM: crc_next = xmodem_byte(crc_start, data_byte);
			MODE_CRC8:   crc_next = crc8_byte(crc_start, data_byte);
			default:     crc_next = crc_start;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= 16'h0000;
			msg_open_q    <= 1'b0;
		end else if (step_en) begin
			running_crc_q <= crc_next;
			msg_open_q    <= ~last_byte;
		end
	end

	assign msg_open = msg_open_q;

endmodule

[sv/multi_mode_crc_byte_engine.sv]
// multi-mode crc byte engine: a byte passes the input register, then the result register
// throughput one byte per cycle when m_tready does not stall; the 8 bit steps of a byte
// fold into one xor stage between the input register and the result register
// async reset clears mode, seed, running crc, message state and both valid flags
// depends on mmcrc_pkg and mmcrc_core
module multi_mode_crc_byte_engine
	import mmcrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] crc_value
	output logic        m_tlast    // final_flag
);

	crc_cfg_t    cfg_q;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        out_valid_q;
	logic [15:0] crc_q;
	logic        final_q;
	logic        advance;
	logic        in_take;
	logic        cfg_wr;
	reg_idx_t    reg_sel;
	logic [15:0] crc_next;
	logic        msg_open;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= MODE_CRC16;
			cfg_q.seed <= 16'h0000;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_MODE: cfg_q.mode <= crc_mode_t'(pwdata[1:0]);
				REG_SEED: cfg_q.seed <= pwdata[15:0];
				default:  cfg_q      <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_MODE: prdata = {30'h0, cfg_q.mode};
			REG_SEED: prdata = {16'h0, cfg_q.seed};
			default:  prdata = 32'h0;
		endcase
	end

	// result register frees when empty or being taken
	assign advance  = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign in_take  = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	mmcrc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.cfg       (cfg_q),
		.crc_next  (crc_next),
		.msg_open  (msg_open)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			crc_q   <= crc_next;
			final_q <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = crc_q;
	assign m_tlast  = final_q;

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |-> !s_tready)
		else $error("input taken while both stages are full");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("result register empty after a byte advanced");

	a_last_closes_msg: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (msg_open == !$past(last_s1)))
		else $error("message state does not follow the last flag");

	a_result_matches_core: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (m_tdata == $past(crc_next)))
		else $error("result register lost the computed crc");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench for multi_mode_crc_byte_engine: random byte messages under all crc modes
// expected crc values come from a local bitwise model; depends on mmcrc_pkg and the engine rtl
module testbench;
	import mmcrc_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} byte_item_t;

	typedef struct {
		logic [15:0] crc;
		logic        is_final;
	} crc_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] data_byte
	logic        s_tlast = 1'b0; // last_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [15:0] crc_value
	logic        m_tlast;        // final_flag

	byte_item_t  pending_bytes[$];
	crc_result_t crc_expected[$];
	crc_mode_t   cfg_mode = MODE_CRC16;
	logic [15:0] cfg_seed = '0;
	logic [15:0] run_crc = '0;
	logic        msg_open = 1'b0;
	logic        no_idle = 1'b0;
	int          send_gap = 0;
	int          recv_stall = 0;
	int          error_count = 0;

	multi_mode_crc_byte_engine DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bitwise crc update of one byte, full 16-bit register in every mode
	function automatic logic [15:0] next_crc(crc_mode_t mode, logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		logic [15:0] poly;
		c = crc;
		poly = (mode == MODE_CRC8) ? 16'h008C : 16'hA001;
		case (mode)
			MODE_CRC16, MODE_CRC8: begin
				c = c ^ {8'h00, b};
				for (int i = 0; i < 8; i++)
					c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
			end
			MODE_XMODEM: begin
				c = c ^ {b, 8'h00};
				for (int i = 0; i < 8; i++)
					c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
			end
			default: ;
		endcase
		return c;
	endfunction

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 5);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'h0000, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_MODE)
			cfg_mode = crc_mode_t'(value[1:0]);
		else
			cfg_seed = value;
	endtask

	task automatic write_mode(input crc_mode_t mode);
		write_reg(REG_MODE, {14'h0000, mode});
	endtask

	task automatic queue_byte(input logic [7:0] data, input logic last);
		pending_bytes.push_back('{data, last});
	endtask

	// hold off until every queued byte went in and every result came back
	task automatic wait_idle();
		while (pending_bytes.size() != 0 || s_tvalid || crc_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// driver: predicts on every accepted transaction, then presents the next byte
	always @(posedge clk) begin : drive_bytes
		byte_item_t  item;
		logic [15:0] start;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				start = msg_open ? run_crc : cfg_seed;
				run_crc = next_crc(cfg_mode, start, s_tdata);
				msg_open = !s_tlast;
				crc_expected.push_back('{run_crc, s_tlast});
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					item = pending_bytes.pop_front();
					s_tdata <= item.data;
					s_tlast <= item.last;
					s_tvalid <= 1'b1;
					send_gap <= draw_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transaction against the oldest prediction
	always @(posedge clk) begin : check_results
		crc_result_t exp_r;
		int          n;
		if (arst_n) begin
			n = recv_stall;
			if (m_tvalid && m_tready) begin
				if (crc_expected.size() == 0) begin
					report_mismatch($sformatf("result crc=%h last=%b with none expected",
						m_tdata, m_tlast));
				end else begin
					exp_r = crc_expected.pop_front();
					if (m_tdata !== exp_r.crc)
						report_mismatch($sformatf("crc_value got %h exp %h", m_tdata, exp_r.crc));
					if (m_tlast !== exp_r.is_final)
						report_mismatch($sformatf("final_flag got %b exp %b",
							m_tlast, exp_r.is_final));
				end
				n = draw_gap();
			end
			if (n > 0) begin
				m_tready <= 1'b0;
				recv_stall <= n - 1;
			end else begin
				m_tready <= 1'b1;
				recv_stall <= 0;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("[multi_mode_crc_byte_engine] ERROR");
		$finish;
	end

	initial begin
		int          p;
		int          k;
		int          len;
		int          n_items;
		int          r;
		logic [15:0] seed;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset config: crc-16 from a zero seed
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h01, 1'b1);
		wait_idle();
		write_mode(MODE_XMODEM);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h80, 1'b1);
		wait_idle();
		// crc-8 with a seed wider than 8 bits
		write_mode(MODE_CRC8);
		write_reg(REG_SEED, 16'hFFFF);
		queue_byte(8'hAA, 1'b0);
		queue_byte(8'h55, 1'b1);
		queue_byte(8'h7E, 1'b1);
		wait_idle();
		// unused mode keeps the seed, message left open
		write_mode(MODE_NONE);
		write_reg(REG_SEED, 16'h1234);
		queue_byte(8'h12, 1'b0);
		queue_byte(8'h34, 1'b1);
		queue_byte(8'h00, 1'b0);
		wait_idle();
		// mode switch in the middle of a message keeps the running value
		write_mode(MODE_CRC16);
		queue_byte(8'h5A, 1'b0);
		wait_idle();
		// seed switch in the middle of a message waits for the next message
		write_reg(REG_SEED, 16'h0000);
		queue_byte(8'hA5, 1'b1);
		queue_byte(8'h3C, 1'b1);
		wait_idle();
		write_mode(MODE_XMODEM);
		write_reg(REG_SEED, 16'hFFFF);
		queue_byte(8'h31, 1'b0);
		queue_byte(8'hCE, 1'b0);
		queue_byte(8'hFF, 1'b1);
		wait_idle();

		for (p = 0; p < 12; p++) begin
			r = $urandom_range(0, 9);
			case ($urandom_range(0, 3))
				0: seed = 16'h0000;
				1: seed = 16'hFFFF;
				2: seed = 16'($urandom_range(0, 255));
				default: seed = 16'($urandom);
			endcase
			if (r < 3)
				write_mode(MODE_CRC16);
			else if (r < 6)
				write_mode(MODE_XMODEM);
			else if (r < 9)
				write_mode(MODE_CRC8);
			else
				write_mode(MODE_NONE);
			write_reg(REG_SEED, seed);
			no_idle = ($urandom_range(0, 3) == 0);
			n_items = 0;
			while (n_items < 60) begin
				if ($urandom_range(0, 7) == 0) begin
					// stray single byte with a random end mark
					queue_byte(8'($urandom), 1'($urandom));
					n_items++;
				end else begin
					len = $urandom_range(1, 12);
					for (k = 0; k < len; k++)
						queue_byte(8'($urandom), k == len - 1);
					n_items += len;
				end
				// sender holds until the pipeline is empty
				if (p == 5 && n_items >= 30 && n_items < 42)
					wait_idle();
			end
			// sometimes leave a message open across the next config change
			if ($urandom_range(0, 2) == 0) begin
				len = $urandom_range(1, 4);
				for (k = 0; k < len; k++)
					queue_byte(8'($urandom), 1'b0);
			end
			wait_idle();
		end

		no_idle = 1'b0;
		repeat (10) @(posedge clk);
		if (crc_expected.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", crc_expected.size()));
		if (error_count == 0)
			$display("[multi_mode_crc_byte_engine] OK");
		else
			$display("[multi_mode_crc_byte_engine] ERROR");
		$finish;
	end

endmodule

[multi_mode_crc_byte_engine.f]
sv/mmcrc_pkg.sv
sv/mmcrc_core.sv
sv/multi_mode_crc_byte_engine.sv
test/testbench.sv
